// ===== hw/rtl/fxdiv_pkg.sv =====
// ---------------------------------------------------------------------------
// fxdiv_pkg: shared types and constants of the 16.16 divider
// Control word layout, program step addresses and datapath flags.
// ---------------------------------------------------------------------------
package fxdiv_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned OVF_SHIFT = 14;

    localparam logic [DATA_W-1:0] QBIT_ONE = 32'h0001_0000;
    localparam logic [DATA_W-1:0] SAT_NEG  = 32'h8000_0000;
    localparam logic [DATA_W-1:0] SAT_POS  = 32'h7FFF_FFFF;

    typedef logic [2:0] t_pc;

    // program step addresses
    localparam t_pc STEP_LOAD  = 3'd0;
    localparam t_pc STEP_MAG_N = 3'd1;
    localparam t_pc STEP_MAG_D = 3'd2;
    localparam t_pc STEP_OVF   = 3'd3;
    localparam t_pc STEP_NORM  = 3'd4;
    localparam t_pc STEP_DIV   = 3'd5;
    localparam t_pc STEP_FIN   = 3'd6;

    typedef enum logic [2:0] {
        ACT_LOAD,
        ACT_MAG_N,
        ACT_MAG_D,
        ACT_OVF,
        ACT_NORM,
        ACT_DIV,
        ACT_FIN
    } t_act;

    typedef enum logic [1:0] {
        ASEL_REM,
        ASEL_REM_SH,
        ASEL_ZERO
    } t_asel;

    typedef enum logic [1:0] {
        BSEL_DV,
        BSEL_ACC,
        BSEL_REM
    } t_bsel;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_NO_WORD,
        COND_GE,
        COND_GT,
        COND_MORE,
        COND_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_act  act;
        t_asel asel;
        t_bsel bsel;
        t_cond cond;
        t_pc   tgt_true;
        t_pc   tgt_false;
    } t_ctrl;

    typedef struct packed {
        logic ge;
        logic gt;
        logic more;
        logic out_busy;
    } t_flags;

endpackage

// ===== hw/rtl/fxdiv_rom.sv =====
// ---------------------------------------------------------------------------
// fxdiv_rom: control store of the divider sequencer
// One control word per program step: action, subtractor operands, jump rule.
// ---------------------------------------------------------------------------
module fxdiv_rom (
    input  fxdiv_pkg::t_pc   i_pc,
    output fxdiv_pkg::t_ctrl o_ctrl
);

    always_comb begin
        unique case (i_pc)
            fxdiv_pkg::STEP_LOAD: begin
                o_ctrl = '{fxdiv_pkg::ACT_LOAD, fxdiv_pkg::ASEL_ZERO, fxdiv_pkg::BSEL_REM,
                           fxdiv_pkg::COND_NO_WORD, fxdiv_pkg::STEP_LOAD,
                           fxdiv_pkg::STEP_MAG_N};
            end
            fxdiv_pkg::STEP_MAG_N: begin
                o_ctrl = '{fxdiv_pkg::ACT_MAG_N, fxdiv_pkg::ASEL_ZERO, fxdiv_pkg::BSEL_REM,
                           fxdiv_pkg::COND_ALWAYS, fxdiv_pkg::STEP_MAG_D,
                           fxdiv_pkg::STEP_MAG_D};
            end
            fxdiv_pkg::STEP_MAG_D: begin
                o_ctrl = '{fxdiv_pkg::ACT_MAG_D, fxdiv_pkg::ASEL_ZERO, fxdiv_pkg::BSEL_DV,
                           fxdiv_pkg::COND_ALWAYS, fxdiv_pkg::STEP_OVF,
                           fxdiv_pkg::STEP_OVF};
            end
            fxdiv_pkg::STEP_OVF: begin
                // saturating words skip straight to the finish step
                o_ctrl = '{fxdiv_pkg::ACT_OVF, fxdiv_pkg::ASEL_REM_SH, fxdiv_pkg::BSEL_DV,
                           fxdiv_pkg::COND_GE, fxdiv_pkg::STEP_FIN,
                           fxdiv_pkg::STEP_NORM};
            end
            fxdiv_pkg::STEP_NORM: begin
                o_ctrl = '{fxdiv_pkg::ACT_NORM, fxdiv_pkg::ASEL_REM, fxdiv_pkg::BSEL_DV,
                           fxdiv_pkg::COND_GT, fxdiv_pkg::STEP_NORM,
                           fxdiv_pkg::STEP_DIV};
            end
            fxdiv_pkg::STEP_DIV: begin
                o_ctrl = '{fxdiv_pkg::ACT_DIV, fxdiv_pkg::ASEL_REM, fxdiv_pkg::BSEL_DV,
                           fxdiv_pkg::COND_MORE, fxdiv_pkg::STEP_DIV,
                           fxdiv_pkg::STEP_FIN};
            end
            fxdiv_pkg::STEP_FIN: begin
                o_ctrl = '{fxdiv_pkg::ACT_FIN, fxdiv_pkg::ASEL_ZERO, fxdiv_pkg::BSEL_ACC,
                           fxdiv_pkg::COND_OUT_BUSY, fxdiv_pkg::STEP_FIN,
                           fxdiv_pkg::STEP_LOAD};
            end
            default: begin
                o_ctrl = '{fxdiv_pkg::ACT_LOAD, fxdiv_pkg::ASEL_ZERO, fxdiv_pkg::BSEL_REM,
                           fxdiv_pkg::COND_NO_WORD, fxdiv_pkg::STEP_LOAD,
                           fxdiv_pkg::STEP_MAG_N};
            end
        endcase
    end

endmodule

// ===== hw/rtl/fxdiv_seq.sv =====
// ---------------------------------------------------------------------------
// fxdiv_seq: step counter of the divider
// Picks the next step from the control word's jump rule and the flags.
// ---------------------------------------------------------------------------
module fxdiv_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fxdiv_pkg::t_ctrl  i_ctrl,
    input  fxdiv_pkg::t_flags i_flags,
    input  logic              i_in_valid,
    output fxdiv_pkg::t_pc    o_pc
);

    fxdiv_pkg::t_pc r_pc;
    fxdiv_pkg::t_pc n_pc;
    logic           taken;

    always_comb begin
        unique case (i_ctrl.cond)
            fxdiv_pkg::COND_ALWAYS:   taken = 1'b1;
            fxdiv_pkg::COND_NO_WORD:  taken = !i_in_valid;
            fxdiv_pkg::COND_GE:       taken = i_flags.ge;
            fxdiv_pkg::COND_GT:       taken = i_flags.gt;
            fxdiv_pkg::COND_MORE:     taken = i_flags.more;
            fxdiv_pkg::COND_OUT_BUSY: taken = i_flags.out_busy;
            default:                  taken = 1'b1;
        endcase
        n_pc = taken ? i_ctrl.tgt_true : i_ctrl.tgt_false;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= fxdiv_pkg::STEP_LOAD;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_pc = r_pc;

endmodule

// ===== hw/rtl/fxdiv_dpath.sv =====
// ---------------------------------------------------------------------------
// fxdiv_dpath: datapath of the divider
// Operand registers, one shared 33-bit subtractor and the output register.
// ---------------------------------------------------------------------------
module fxdiv_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fxdiv_pkg::t_ctrl  i_ctrl,
    input  logic [31:0]       i_dividend,
    input  logic [31:0]       i_divisor,
    input  logic              i_out_stall,
    output fxdiv_pkg::t_flags o_flags,
    output logic [31:0]       o_quotient,
    output logic              o_saturated,
    output logic              o_out_valid
);

    logic [31:0] r_rem, n_rem;
    logic [31:0] r_dv, n_dv;
    logic [31:0] r_qbit, n_qbit;
    logic [31:0] r_acc, n_acc;
    logic        r_neg, n_neg;
    logic        r_sat, n_sat;
    logic [31:0] r_quot, n_quot;
    logic        r_osat, n_osat;
    logic        r_ovalid, n_ovalid;

    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [32:0] diff;
    logic        ge;
    logic        out_busy;
    logic        fin_fire;
    logic [31:0] rem_sub;
    logic [31:0] rem_next;
    logic [31:0] qbit_next;

    // shared subtractor
    always_comb begin
        case (i_ctrl.asel)
            fxdiv_pkg::ASEL_REM:    op_a = r_rem;
            fxdiv_pkg::ASEL_REM_SH: op_a = r_rem >> fxdiv_pkg::OVF_SHIFT;
            default:                op_a = '0;
        endcase
        case (i_ctrl.bsel)
            fxdiv_pkg::BSEL_DV:  op_b = r_dv;
            fxdiv_pkg::BSEL_ACC: op_b = r_acc;
            default:             op_b = r_rem;
        endcase
        diff = {1'b0, op_a} - {1'b0, op_b};
        ge   = !diff[32];
    end

    assign out_busy  = r_ovalid && i_out_stall;
    assign fin_fire  = (i_ctrl.act == fxdiv_pkg::ACT_FIN) && !out_busy;
    assign rem_sub   = ge ? diff[31:0] : r_rem;
    assign rem_next  = rem_sub << 1;
    assign qbit_next = r_qbit >> 1;

    assign o_flags.ge       = ge;
    assign o_flags.gt       = ge && (diff[31:0] != '0);
    assign o_flags.more     = (qbit_next != '0) && (rem_next != '0);
    assign o_flags.out_busy = out_busy;

    always_comb begin
        n_rem  = r_rem;
        n_dv   = r_dv;
        n_qbit = r_qbit;
        n_acc  = r_acc;
        n_neg  = r_neg;
        n_sat  = r_sat;
        n_quot = r_quot;
        n_osat = r_osat;
        unique case (i_ctrl.act)
            fxdiv_pkg::ACT_LOAD: begin
                n_rem = i_dividend;
                n_dv  = i_divisor;
                n_neg = i_dividend[31] ^ i_divisor[31];
            end
            fxdiv_pkg::ACT_MAG_N: begin
                if (r_rem[31]) begin
                    n_rem = diff[31:0];
                end
            end
            fxdiv_pkg::ACT_MAG_D: begin
                if (r_dv[31]) begin
                    n_dv = diff[31:0];
                end
            end
            fxdiv_pkg::ACT_OVF: begin
                if (ge) begin
                    // load the saturated value and drop the sign fix-up
                    n_acc = r_neg ? fxdiv_pkg::SAT_NEG : fxdiv_pkg::SAT_POS;
                    n_neg = 1'b0;
                    n_sat = 1'b1;
                end else begin
                    n_acc  = '0;
                    n_qbit = fxdiv_pkg::QBIT_ONE;
                    n_sat  = 1'b0;
                end
            end
            fxdiv_pkg::ACT_NORM: begin
                if (o_flags.gt) begin
                    n_dv   = r_dv << 1;
                    n_qbit = r_qbit << 1;
                end
            end
            fxdiv_pkg::ACT_DIV: begin
                n_rem  = rem_next;
                n_qbit = qbit_next;
                if (ge) begin
                    n_acc = r_acc | r_qbit;
                end
            end
            fxdiv_pkg::ACT_FIN: begin
                if (fin_fire) begin
                    n_quot = r_neg ? diff[31:0] : r_acc;
                    n_osat = r_sat;
                end
            end
            default: begin
                n_rem = r_rem;
            end
        endcase
        n_ovalid = fin_fire || out_busy;
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_dv   <= n_dv;
        r_qbit <= n_qbit;
        r_acc  <= n_acc;
        r_neg  <= n_neg;
        r_sat  <= n_sat;
        r_quot <= n_quot;
        r_osat <= n_osat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= n_ovalid;
        end
    end

    assign o_quotient  = r_quot;
    assign o_saturated = r_osat;
    assign o_out_valid = r_ovalid;

endmodule

// ===== hw/rtl/fixed_16_16_divide.sv =====
// ---------------------------------------------------------------------------
// fixed_16_16_divide: signed 16.16 fixed-point divider with saturation
// Microcoded sequencer driving a shift-subtract datapath.
// ---------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry a word of i_dividend and
// i_divisor. Output channel: o_out_valid / i_out_stall carry o_quotient and
// o_saturated. A word moves on an edge where valid is high and stall low.
// One word is worked at a time; o_in_stall is high from the edge after
// acceptance until the step counter returns to its load step.
// From acceptance a word passes the magnitude steps and the overflow check;
// a saturating word (overflow or zero divisor) then goes to the finish step,
// any other word first goes through n normalising shifts of the divisor (n
// up to 14) and k shift-subtract steps (k up to 31). Every step uses the
// single shared 33-bit subtractor, which also forms the operand magnitudes
// and the final negation; the next word can be taken in the cycle after the
// result loads. The result sits in an output register, so a stalled receiver
// holds it there; the sequencer waits in its finish step only when a second
// result is ready while the first is still held.
// Reset (synchronous, active low) returns the step counter to the load step
// and empties the output register.
// ---------------------------------------------------------------------------
module fixed_16_16_divide (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_dividend,
    input  logic signed [31:0] i_divisor,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_quotient,
    output logic               o_saturated
);

    fxdiv_pkg::t_pc    pc;
    fxdiv_pkg::t_ctrl  ctrl;
    fxdiv_pkg::t_flags flags;
    logic [31:0]       quot;

    fxdiv_rom u_rom (
        .i_pc   (pc),
        .o_ctrl (ctrl)
    );

    fxdiv_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (ctrl),
        .i_flags    (flags),
        .i_in_valid (i_in_valid),
        .o_pc       (pc)
    );

    fxdiv_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_dividend  ($unsigned(i_dividend)),
        .i_divisor   ($unsigned(i_divisor)),
        .i_out_stall (i_out_stall),
        .o_flags     (flags),
        .o_quotient  (quot),
        .o_saturated (o_saturated),
        .o_out_valid (o_out_valid)
    );

    // hold off new words outside the load step and while in reset
    assign o_in_stall = (ctrl.act != fxdiv_pkg::ACT_LOAD) || !i_rst_n;
    assign o_quotient = $signed(quot);

endmodule

// ===== hw/rtl/fxdiv_chk.sv =====
// ---------------------------------------------------------------------------
// fxdiv_chk: port-level checks of the 16.16 divider
// Watches the channels of the top level; attached by bind.
// ---------------------------------------------------------------------------
module fxdiv_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic signed [31:0] i_dividend,
    input logic signed [31:0] i_divisor,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [31:0] o_quotient,
    input logic               o_saturated
);

    logic in_acc;

    assign in_acc = i_in_valid && !o_in_stall;

    // hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_quotient)
            && $stable(o_saturated))
        else $error("stalled result word changed");

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated |->
            ($unsigned(o_quotient) == fxdiv_pkg::SAT_POS)
            || ($unsigned(o_quotient) == fxdiv_pkg::SAT_NEG))
        else $error("saturated word is not an end-of-range value");

    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("second word taken while a division is in progress");

    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !$rose(o_out_valid) ##1 !$rose(o_out_valid))
        else $error("result appeared sooner than the shortest program");

endmodule

bind fixed_16_16_divide fxdiv_chk u_chk (.*);
